>>> hw/rtl/deadline_timer_queue_core_defines.svh
// Assertion macros shared by the deadline timer queue RTL.
// Included by the top level, which holds the concurrent checks.
`ifndef DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_CORE_DEFINES_SVH

// Implication checked in the same cycle, off while reset is asserted.
`define DTQ_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("deadline timer queue check failed");

// Implication checked in the next cycle, off while reset is asserted.
`define DTQ_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("deadline timer queue check failed");

`endif

>>> hw/rtl/dtq_pkg.sv
// Shared constants, types and helpers of the deadline timer queue.
// No dependencies; the top level and the engine import it.
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int AW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);
  localparam int TW          = 63;
  localparam int ID_W        = 8;
  localparam int OP_W        = 3;
  localparam int KIND_W      = 2;
  localparam int IN_DW       = ((ID_W + TW + 7) / 8) * 8;
  localparam int OUT_DW      = ((ID_W + 1 + TW + 7) / 8) * 8;

  localparam logic [TW-1:0] TIME_MAX = '1;
  localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_POST_AT     = 3'd0,
    OP_POST_AFTER  = 3'd1,
    OP_CANCEL      = 3'd2,
    OP_RUN_UNTIL   = 3'd3,
    OP_RUN_FOR     = 3'd4,
    OP_RUN_IDLE    = 3'd5,
    OP_SHUTDOWN    = 3'd6
  } dtq_op_t;

  typedef enum logic [KIND_W-1:0] {
    EV_FIRED     = 2'd0,
    EV_CANCELLED = 2'd1,
    EV_DONE      = 2'd2
  } dtq_kind_t;

  // One queue slot as stored in the memory.
  typedef struct packed {
    logic [TW-1:0]   dl;
    logic [ID_W-1:0] task_id;
  } dtq_entry_t;

  localparam int ENTRY_W = $bits(dtq_entry_t);

  // One result item handed from the engine to the output register.
  typedef struct packed {
    dtq_kind_t       kind;
    logic [ID_W-1:0] task_id;
    logic            res;
    logic [TW-1:0]   now;
    logic            last;
  } dtq_event_t;

  typedef struct packed {
    logic          shut;
    logic [CW-1:0] count;
  } dtq_status_t;

  // Circular index: base plus offset, wrapped at the queue depth.
  function automatic logic [AW-1:0] dtq_wrap(input logic [AW-1:0] base,
                                             input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (AW+1)'(QUEUE_DEPTH)) s = s - (AW+1)'(QUEUE_DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

>>> hw/rtl/deadline_timer_queue_core.sv
// Deadline timer queue, one operation at a time: in_tready is high only in the idle cycle.
// A post searches the queue for its id and then inserts in deadline order; a cancel searches
// one slot per cycle through the single read port of the slot memory; a run fires due tasks
// timer step by timer step; a shutdown cancels every pending task. The completion item passes
// the output register, output stalls delay it, and the next transfer is accepted after that.
// Synchronous active-low reset clears state, count, head, time, expiry, result, shutdown and output valid only.
`include "deadline_timer_queue_core_defines.svh"

module deadline_timer_queue_core import dtq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // task_id [7:0], time_value [70:8], zero pad
  input  logic [OP_W-1:0]   in_tuser,   // opcode [2:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // event_task [7:0], op_result [8], time_now [71:9]
  output logic [KIND_W-1:0] out_tuser,  // event_kind [1:0]
  output logic              out_tlast
);

  logic                ev_valid;
  logic                ev_ready;
  dtq_event_t          ev;
  dtq_status_t         eng_stat;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  dtq_entry_t          mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata_raw;
  dtq_entry_t          mem_rdata;
  logic                out_vld_r;
  dtq_event_t          out_ev_r;

  assign mem_rdata = dtq_entry_t'(mem_rdata_raw);

  dtq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  dtq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_id     (in_tdata[ID_W-1:0]),
    .in_time   (in_tdata[ID_W+TW-1:ID_W]),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .stat      (eng_stat)
  );

  // Output register: a result waiting for its transfer stalls the engine only at its next result.
  assign ev_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ev_ready) begin
      out_vld_r <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_valid && ev_ready) begin
      out_ev_r <= ev;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_ev_r.now, out_ev_r.res, out_ev_r.task_id};
  assign out_tuser  = out_ev_r.kind;
  assign out_tlast  = out_ev_r.last;

  `DTQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, eng_stat.count <= DEPTH_C)
  `DTQ_ASSERT_NOW(a_shut_empty, clk, rst_n, eng_stat.shut, eng_stat.count == '0)
  `DTQ_ASSERT_NEXT(a_ev_lands, clk, rst_n, ev_valid && ev_ready, out_tvalid)
  `DTQ_ASSERT_NEXT(a_one_op, clk, rst_n, in_tvalid && in_tready, !in_tready)

endmodule

>>> hw/rtl/dtq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; holds the queue slots of the deadline timer queue.
module dtq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/dtq_engine.sv
// Operation sequencer of the deadline timer queue: search, shift, insert,
// dispatch and shutdown walks over the slot memory. Depends on dtq_pkg.
module dtq_engine import dtq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ID_W-1:0]   in_id,
  input  logic [TW-1:0]     in_time,
  output logic              ev_valid,
  input  logic              ev_ready,
  output dtq_event_t        ev,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output dtq_entry_t        mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  dtq_entry_t        mem_rdata,
  output dtq_status_t       stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_FIND_RD, S_FIND_CMP, S_REM_MV, S_REM_END, S_INS_START, S_INS,
    S_INS_HEAD, S_RUN_CHK, S_FIRE_RD, S_FIRE_EV, S_FIRE_END, S_SD_RD, S_SD_EV,
    S_CANC_EV, S_DONE
  } state_t;

  state_t          st_r, st_nxt;
  dtq_op_t         op_r, op_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [TW-1:0]   tgt_r, tgt_nxt;
  logic [TW-1:0]   now_r, now_nxt;
  logic [TW-1:0]   nx_r, nx_nxt;
  logic [TW-1:0]   fdl_r, fdl_nxt;
  logic [TW-1:0]   d1_r, d1_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   hd_r, hd_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic            res_r, res_nxt;
  logic            shut_r, shut_nxt;

  logic            is_post;
  logic [CW-1:0]   idx1, j1, j2, jm1, jm2, cm1;
  dtq_entry_t      new_ent;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                            input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? TIME_MAX : s[TW-1:0];
  endfunction

  assign is_post = (op_r == OP_POST_AT) || (op_r == OP_POST_AFTER);
  assign idx1    = idx_r + CW'(1);
  assign j1      = j_r + CW'(1);
  assign j2      = j_r + CW'(2);
  assign jm1     = j_r - CW'(1);
  assign jm2     = j_r - CW'(2);
  assign cm1     = cnt_r - CW'(1);
  assign new_ent = '{dl: tgt_r, task_id: id_r};

  assign in_ready = (st_r == S_IDLE);
  assign stat     = '{shut: shut_r, count: cnt_r};

  always_comb begin
    st_nxt    = st_r;
    op_nxt    = op_r;
    id_nxt    = id_r;
    tgt_nxt   = tgt_r;
    now_nxt   = now_r;
    nx_nxt    = nx_r;
    fdl_nxt   = fdl_r;
    d1_nxt    = d1_r;
    cnt_nxt   = cnt_r;
    hd_nxt    = hd_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    res_nxt   = res_r;
    shut_nxt  = shut_r;
    mem_we    = 1'b0;
    mem_waddr = dtq_wrap(hd_r, j_r[AW-1:0]);
    mem_wdata = new_ent;
    mem_re    = 1'b0;
    mem_raddr = hd_r;
    ev_valid  = 1'b0;
    ev        = '{kind: EV_DONE, task_id: '0, res: 1'b0, now: now_r, last: 1'b0};

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = dtq_op_t'(in_op);
          id_nxt  = in_id;
          res_nxt = 1'b0;
          unique case (in_op) inside
            OP_POST_AFTER, OP_RUN_FOR: tgt_nxt = sat_add(now_r, in_time);
            OP_RUN_IDLE:               tgt_nxt = now_r;
            default:                   tgt_nxt = in_time;
          endcase
          unique case (in_op) inside
            OP_POST_AT, OP_POST_AFTER: st_nxt = shut_r ? S_CANC_EV : S_FIND_RD;
            OP_CANCEL:                 st_nxt = shut_r ? S_DONE : S_FIND_RD;
            OP_RUN_UNTIL, OP_RUN_FOR, OP_RUN_IDLE: begin
              st_nxt = shut_r ? S_DONE : S_RUN_CHK;
            end
            OP_SHUTDOWN: begin
              if (shut_r) begin
                st_nxt = S_DONE;
              end else begin
                res_nxt = (cnt_r != '0);
                st_nxt  = S_SD_RD;
              end
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end

      S_FIND_RD: begin
        if (cnt_r == '0) begin
          st_nxt = is_post ? S_INS_START : S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = hd_r;
          idx_nxt   = '0;
          st_nxt    = S_FIND_CMP;
        end
      end

      // Compare one slot per cycle; the following slot is fetched ahead,
      // which is also the first read of the shift when this one matches.
      S_FIND_CMP: begin
        if (idx1 < cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = dtq_wrap(hd_r, idx1[AW-1:0]);
        end
        if (mem_rdata.task_id == id_r) begin
          fdl_nxt = mem_rdata.dl;
          j_nxt   = idx_r;
          if (idx1 < cnt_r) begin
            st_nxt = S_REM_MV;
          end else begin
            cnt_nxt = cm1;
            st_nxt  = S_REM_END;
          end
        end else if (idx1 >= cnt_r) begin
          if (!is_post) begin
            st_nxt = S_DONE;
          end else if (cnt_r >= DEPTH_C) begin
            st_nxt = S_CANC_EV;
          end else begin
            st_nxt = S_INS_START;
          end
        end else begin
          idx_nxt = idx1;
        end
      end

      S_REM_MV: begin
        mem_we    = 1'b1;
        mem_waddr = dtq_wrap(hd_r, j_r[AW-1:0]);
        mem_wdata = mem_rdata;
        if (j_r == '0) d1_nxt = mem_rdata.dl;
        if (j2 < cnt_r) begin
          mem_re    = 1'b1;
          mem_raddr = dtq_wrap(hd_r, j2[AW-1:0]);
          j_nxt     = j1;
        end else begin
          cnt_nxt = cm1;
          st_nxt  = S_REM_END;
        end
      end

      S_REM_END: begin
        if (is_post) begin
          st_nxt = S_INS_START;
        end else begin
          // A cancelled head re-arms the timer unless its successor ties; an emptied queue disarms it.
          res_nxt = 1'b1;
          if (idx_r == '0) begin
            if (cnt_r == '0) begin
              nx_nxt = TIME_MAX;
            end else if (d1_r > fdl_r) begin
              nx_nxt = d1_r;
            end
          end
          st_nxt = S_DONE;
        end
      end

      S_INS_START: begin
        j_nxt = cnt_r;
        if (cnt_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = hd_r;
          nx_nxt    = tgt_r;
          cnt_nxt   = cnt_r + CW'(1);
          st_nxt    = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = dtq_wrap(hd_r, cm1[AW-1:0]);
          st_nxt    = S_INS;
        end
      end

      // Walk from the tail toward the head, moving later deadlines up.
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = dtq_wrap(hd_r, j_r[AW-1:0]);
        if (mem_rdata.dl > tgt_r) begin
          mem_wdata = mem_rdata;
          if (j_r == CW'(1)) begin
            st_nxt = S_INS_HEAD;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = dtq_wrap(hd_r, jm2[AW-1:0]);
            j_nxt     = jm1;
          end
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          st_nxt  = S_DONE;
        end
      end

      S_INS_HEAD: begin
        mem_we    = 1'b1;
        mem_waddr = hd_r;
        nx_nxt    = tgt_r;
        cnt_nxt   = cnt_r + CW'(1);
        st_nxt    = S_DONE;
      end

      S_RUN_CHK: begin
        if (tgt_r < nx_r) begin
          now_nxt = tgt_r;
          st_nxt  = S_DONE;
        end else begin
          now_nxt = nx_r;
          nx_nxt  = TIME_MAX;
          st_nxt  = S_FIRE_RD;
        end
      end

      S_FIRE_RD: begin
        if (cnt_r == '0) begin
          st_nxt = S_FIRE_END;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = hd_r;
          st_nxt    = S_FIRE_EV;
        end
      end

      S_FIRE_EV: begin
        if (mem_rdata.dl <= now_r) begin
          ev_valid   = 1'b1;
          ev.kind    = EV_FIRED;
          ev.task_id = mem_rdata.task_id;
          if (ev_ready) begin
            hd_nxt  = dtq_wrap(hd_r, AW'(1));
            cnt_nxt = cm1;
            res_nxt = 1'b1;
            st_nxt  = S_FIRE_RD;
          end
        end else begin
          nx_nxt = mem_rdata.dl;
          st_nxt = S_FIRE_END;
        end
      end

      S_FIRE_END: begin
        st_nxt = (now_r == TIME_MAX) ? S_DONE : S_RUN_CHK;
      end

      S_SD_RD: begin
        if (cnt_r == '0) begin
          shut_nxt = 1'b1;
          st_nxt   = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = hd_r;
          st_nxt    = S_SD_EV;
        end
      end

      S_SD_EV: begin
        ev_valid   = 1'b1;
        ev.kind    = EV_CANCELLED;
        ev.task_id = mem_rdata.task_id;
        if (ev_ready) begin
          hd_nxt  = dtq_wrap(hd_r, AW'(1));
          cnt_nxt = cm1;
          st_nxt  = S_SD_RD;
        end
      end

      S_CANC_EV: begin
        ev_valid   = 1'b1;
        ev.kind    = EV_CANCELLED;
        ev.task_id = id_r;
        if (ev_ready) st_nxt = S_DONE;
      end

      S_DONE: begin
        ev_valid = 1'b1;
        ev.kind  = EV_DONE;
        ev.res   = res_r;
        ev.last  = 1'b1;
        if (ev_ready) st_nxt = S_IDLE;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      now_r  <= '0;
      nx_r   <= TIME_MAX;
      cnt_r  <= '0;
      hd_r   <= '0;
      res_r  <= 1'b0;
      shut_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      op_r   <= op_nxt;
      id_r   <= id_nxt;
      tgt_r  <= tgt_nxt;
      now_r  <= now_nxt;
      nx_r   <= nx_nxt;
      fdl_r  <= fdl_nxt;
      d1_r   <= d1_nxt;
      cnt_r  <= cnt_nxt;
      hd_r   <= hd_nxt;
      idx_r  <= idx_nxt;
      j_r    <= j_nxt;
      res_r  <= res_nxt;
      shut_r <= shut_nxt;
    end
  end

endmodule
